// ===== sv/tcts_pkg.sv =====
// ============================================================================
// tcts_pkg: shared types and codes of the timed cue trigger scheduler
// Request payload structs, op/kind/status codes, register indexes, FSM states.
// ============================================================================
package tcts_pkg;

    localparam int OP_W     = 2;
    localparam int CUE_W    = 5;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    // op codes of an input request
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    // op 3 has no meaning; it is swallowed without a result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // kind of a result
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // status of a result
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_CUE     = 2'd1;
    localparam logic [1:0] ST_NOT_AUTH    = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOWED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ALLOWED = 1'd1;

    localparam logic [CFG_W-1:0] CUE_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CUE_W-1:0]  cue_number;
        logic [TIME_W-1:0] trigger_ms;
        logic              arm_authorised;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [CUE_W-1:0] cue_fired;
        logic             show_running;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

// ===== sv/tcts_cue_store.sv =====
// ============================================================================
// tcts_cue_store: cue time memory
// One write port, one registered read port; entries never written read as 0.
// ============================================================================
module tcts_cue_store
    import tcts_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [TIME_W-1:0]                      wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [TIME_W-1:0]                      rd_data
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic              rd_hit_reg;

    // written flags stand in for the all-zero reset of the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== sv/tcts_out_reg.sv =====
// ============================================================================
// tcts_out_reg: result output register
// Holds one result request until the consumer takes it.
// ============================================================================
module tcts_out_reg
    import tcts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

endmodule

// ===== sv/timed_cue_trigger_scheduler.sv =====
// ============================================================================
// timed_cue_trigger_scheduler: millisecond cue firing scheduler
// Stores per-cue firing times, starts a show and fires due cues on each tick.
// ============================================================================
// Takes one request at a time. A set or start request is latched, then
// executed in S_EXEC, which loads the result register once it can take a
// result. While the show runs, a tick request scans the active cues with one
// shared compare unit reading the cue time memory through its single
// registered read port, one entry per cycle with the memory read pipelined
// one ahead of the compare; it then walks the due list and emits one result
// per fired cue plus the closing result, stalling while the consumer holds
// out_ready low. A tick while stopped gives the closing result only. Results
// carry the running flag as it stands after the whole request, so a tick
// decides the running flag at the end of the scan, before its first result
// goes out. The effective cue count is the cue_count register clipped to
// MAX_CUES. Configuration is always accepted (cfg_ready is high) and must
// only be written while idle.
module timed_cue_trigger_scheduler
    import tcts_pkg::*;
#(
    parameter int MAX_CUES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // request input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item
);

    // index width of the cue arrays, and a count width that holds MAX_CUES
    // and the 5-bit register values alike
    localparam int IDX_W = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
    localparam int CNT_W = $clog2(MAX_CUES + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    state_t              state_reg, state_next;

    // latched request
    logic [OP_W-1:0]     op_reg;
    logic [CUE_W-1:0]    cue_reg;
    logic [TIME_W-1:0]   tms_reg;
    logic                armed_reg;

    // configuration
    logic [CFG_W-1:0]    cue_count_reg;
    logic                show_allowed_reg;

    // show state
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                running_reg, running_next;
    logic [CW-1:0]       fired_total_reg, fired_total_next;
    logic [MAX_CUES-1:0] fired_reg, fired_next;
    logic [MAX_CUES-1:0] pending_reg, pending_next;

    // scan sequencer
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;

    // memory and output register hookup
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    logic                mem_rd_en;
    logic [TIME_W-1:0]   mem_rd_data;
    logic                res_load;
    out_item_t           res_item;
    logic                can_load;

    logic [CW-1:0]       count_raw;
    logic [CW-1:0]       eff_count;
    logic [CW-1:0]       cue_ext;
    logic [CW-1:0]       set_addr;
    logic                cue_due;

    assign count_raw = CW'(cue_count_reg);
    assign eff_count = (count_raw > CW'(MAX_CUES)) ? CW'(MAX_CUES) : count_raw;
    assign cue_ext   = CW'(cue_reg);
    assign set_addr  = cue_ext - CW'(1);

    // shared compare unit: unfired cue whose time has come
    assign cue_due = !fired_reg[cmp_idx_reg] && (mem_rd_data <= elapsed_reg);

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign mem_wr_addr = set_addr[IDX_W-1:0];

    tcts_cue_store #(
        .DEPTH(MAX_CUES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (tms_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    tcts_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_item (res_item),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cue_count_reg    <= CUE_COUNT_RST;
            show_allowed_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CUE_COUNT:    cue_count_reg    <= cfg_data;
                CFG_SHOW_ALLOWED: show_allowed_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= in_item.op;
            cue_reg   <= in_item.cue_number;
            tms_reg   <= in_item.trigger_ms;
            armed_reg <= in_item.arm_authorised;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            elapsed_reg     <= '0;
            running_reg     <= 1'b0;
            fired_total_reg <= '0;
            fired_reg       <= '0;
            pending_reg     <= '0;
            scan_idx_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            elapsed_reg     <= elapsed_next;
            running_reg     <= running_next;
            fired_total_reg <= fired_total_next;
            fired_reg       <= fired_next;
            pending_reg     <= pending_next;
            scan_idx_reg    <= scan_idx_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_idx_reg     <= cmp_idx_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        elapsed_next     = elapsed_reg;
        running_next     = running_reg;
        fired_total_next = fired_total_reg;
        fired_next       = fired_reg;
        pending_next     = pending_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        res_load         = 1'b0;
        res_item         = '0;

        case (state_reg)
            S_IDLE:
            begin
                // op 3 is dropped right at the input
                if (in_valid && (in_item.op != OP_UNUSED))
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    OP_SET:
                    begin
                        if (can_load)
                        begin
                            res_load              = 1'b1;
                            res_item.kind         = KIND_SET;
                            res_item.show_running = running_reg;
                            res_item.last         = 1'b1;
                            if (cue_reg == '0 || cue_ext > eff_count)
                            begin
                                res_item.status = ST_BAD_CUE;
                            end
                            else
                            begin
                                res_item.status = ST_OK;
                                mem_wr_en       = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end

                    OP_START:
                    begin
                        if (can_load)
                        begin
                            res_load      = 1'b1;
                            res_item.kind = KIND_START;
                            res_item.last = 1'b1;
                            res_item.show_running = running_reg;
                            if (!armed_reg)
                            begin
                                res_item.status = ST_NOT_AUTH;
                            end
                            else if (!show_allowed_reg)
                            begin
                                res_item.status = ST_NOT_ALLOWED;
                            end
                            else
                            begin
                                res_item.status       = ST_OK;
                                res_item.show_running = 1'b1;
                                fired_next            = '0;
                                fired_total_next      = '0;
                                elapsed_next          = '0;
                                running_next          = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end

                    OP_TICK:
                    begin
                        if (running_reg)
                        begin
                            if (elapsed_reg != '1)
                            begin
                                elapsed_next = elapsed_reg + TIME_W'(1);
                            end
                            scan_idx_next  = '0;
                            cmp_valid_next = 1'b0;
                            pending_next   = '0;
                            state_next     = S_SCAN;
                        end
                        else if (can_load)
                        begin
                            // stopped: closing result only
                            res_load              = 1'b1;
                            res_item.kind         = KIND_TICK;
                            res_item.status       = ST_OK;
                            res_item.show_running = 1'b0;
                            res_item.last         = 1'b1;
                            state_next            = S_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                // compare stage: entry read on the previous cycle
                if (cmp_valid_reg && cue_due)
                begin
                    fired_next[cmp_idx_reg]   = 1'b1;
                    pending_next[cmp_idx_reg] = 1'b1;
                    fired_total_next          = fired_total_reg + CW'(1);
                end
                // read stage
                if (scan_idx_reg < eff_count)
                begin
                    mem_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CW'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg)
                    begin
                        // all compares retired: running flag is final now
                        running_next  = !(fired_total_reg >= eff_count);
                        scan_idx_next = '0;
                        state_next    = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (scan_idx_reg >= eff_count)
                begin
                    if (can_load)
                    begin
                        res_load              = 1'b1;
                        res_item.kind         = KIND_TICK;
                        res_item.status       = ST_OK;
                        res_item.show_running = running_reg;
                        res_item.last         = 1'b1;
                        state_next            = S_IDLE;
                    end
                end
                else if (pending_reg[scan_idx_reg[IDX_W-1:0]])
                begin
                    if (can_load)
                    begin
                        res_load              = 1'b1;
                        res_item.kind         = KIND_TICK;
                        res_item.status       = ST_OK;
                        res_item.cue_fired    = CUE_W'(scan_idx_reg + CW'(1));
                        res_item.show_running = running_reg;
                        res_item.last         = 1'b0;
                        pending_next[scan_idx_reg[IDX_W-1:0]] = 1'b0;
                        scan_idx_next         = scan_idx_reg + CW'(1);
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
